// ===== rtl/lod_level_hysteresis_blender_unit_macros.svh =====
// Assertion macros shared by the level-of-detail blender modules.
`ifndef LOD_LEVEL_HYSTERESIS_BLENDER_UNIT_MACROS_SVH
`define LOD_LEVEL_HYSTERESIS_BLENDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHBU_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LHBU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lhbu_pkg.sv =====
// Shared types, constants and field layout for the level-of-detail blender.
`timescale 1ns / 1ps
`default_nettype none
package lhbu_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int LEVELS_DEF = 4;

  // Field widths
  localparam int SLOT_W  = 4;
  localparam int DIST_W  = 24;
  localparam int TIME_W  = 16;
  localparam int LVL_W   = 3;
  localparam int BLEND_W = 18;
  localparam int BIAS_W  = 10;
  localparam int HYST_W  = 8;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 19;
  localparam int STEP_W  = 24;
  localparam int PROD_W  = 43;
  localparam int SUM_W   = 27;

  // Input tdata layout, lowest bit first
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_CAM_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_FT_LSB   = IN_CAM_LSB + DIST_W;
  localparam int IN_D0_LSB   = IN_FT_LSB + TIME_W;
  localparam int IN_D1_LSB   = IN_D0_LSB + DIST_W;
  localparam int IN_D2_LSB   = IN_D1_LSB + DIST_W;
  localparam int IN_D3_LSB   = IN_D2_LSB + DIST_W;
  localparam int IN_USED_W   = IN_D3_LSB + DIST_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_SLOT_LSB  = 0;
  localparam int OUT_SHOWN_LSB = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_WANT_LSB  = OUT_SHOWN_LSB + LVL_W;
  localparam int OUT_BLEND_LSB = OUT_WANT_LSB + LVL_W;
  localparam int OUT_USED_W    = OUT_BLEND_LSB + BLEND_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_FRAC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_EN    = 3'd5;

  localparam logic [BIAS_W-1:0]  BIAS_RST  = 10'd384;
  localparam logic [BIAS_W-1:0]  BIAS_MIN  = 10'd128;
  localparam logic [BIAS_W-1:0]  BIAS_MAX  = 10'd768;
  localparam logic [HYST_W-1:0]  HYST_RST  = 8'd38;
  localparam logic [SPEED_W-1:0] SPEED_RST = 16'd512;
  localparam logic [LVL_W-1:0]   TOP_RST   = 3'd4;

  localparam logic [HYST_W:0]     HYST_ONE  = 9'd256;
  localparam logic [SUM_W-1:0]    BLEND_ONE = 27'd65536;

  // Function codes carried in tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic [BIAS_W-1:0]  bias_gain;
    logic [HYST_W-1:0]  hyst_frac;
    logic [SPEED_W-1:0] ramp_speed;
    logic [LVL_W-1:0]   top_level;
    logic               smooth_en;
    logic               block_en;
  } cfg_t;

  // Per-slot dynamic state row
  typedef struct packed {
    logic [LVL_W-1:0]   cur;
    logic [LVL_W-1:0]   tgt;
    logic [BLEND_W-1:0] blend;
  } row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_CMP,
    S_RAMP,
    S_LOAD,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_LOAD,
    RES_HOLD,
    RES_RAMP
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     fetch;
    logic     mul;
    logic     step_i;
    logic     tgt_set;
    logic     tgt_top;
    res_sel_t res_sel;
    logic     load_wr;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic slot_oor;
    logic is_load;
    logic entry_ok;
    logic enabled;
    logic top_zero;
    logic hit;
    logic last;
    logic load_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/lhbu_ctrl.sv =====
// Sequencer for the level-of-detail blender: state machine issuing datapath commands.
`timescale 1ns / 1ps
`default_nettype none
`include "lod_level_hysteresis_blender_unit_macros.svh"
module lhbu_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lhbu_pkg::status_t   st,
  output lhbu_pkg::cmd_t      cmd
);

  lhbu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lhbu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lhbu_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lhbu_pkg::S_FETCH;
      end
      lhbu_pkg::S_FETCH: begin
        priority if (st.slot_oor) state_nxt = lhbu_pkg::S_DONE;
        else if (st.is_load)      state_nxt = lhbu_pkg::S_LOAD;
        else if (!st.entry_ok)    state_nxt = lhbu_pkg::S_DONE;
        else if (!st.enabled)     state_nxt = lhbu_pkg::S_DONE;
        else if (st.top_zero)     state_nxt = lhbu_pkg::S_RAMP;
        else                      state_nxt = lhbu_pkg::S_MUL;
      end
      lhbu_pkg::S_MUL: state_nxt = lhbu_pkg::S_CMP;
      lhbu_pkg::S_CMP: begin
        if (st.hit || st.last) state_nxt = lhbu_pkg::S_RAMP;
        else                   state_nxt = lhbu_pkg::S_MUL;
      end
      lhbu_pkg::S_RAMP: state_nxt = lhbu_pkg::S_DONE;
      lhbu_pkg::S_LOAD: begin
        if (st.load_last) state_nxt = lhbu_pkg::S_DONE;
      end
      lhbu_pkg::S_DONE: begin
        if (st.out_free) state_nxt = lhbu_pkg::S_IDLE;
      end
      default: state_nxt = lhbu_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lhbu_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lhbu_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
        priority if (st.slot_oor) cmd.res_sel = lhbu_pkg::RES_ZERO;
        else if (st.is_load)      cmd.res_sel = lhbu_pkg::RES_NONE;
        else if (!st.entry_ok)    cmd.res_sel = lhbu_pkg::RES_ZERO;
        else if (!st.enabled)     cmd.res_sel = lhbu_pkg::RES_HOLD;
        else if (st.top_zero) begin
          cmd.tgt_set = 1'b1;
          cmd.tgt_top = 1'b1;
        end else begin
          cmd.res_sel = lhbu_pkg::RES_NONE;
        end
      end
      lhbu_pkg::S_MUL: cmd.mul = 1'b1;
      lhbu_pkg::S_CMP: begin
        priority if (st.hit) begin
          cmd.tgt_set = 1'b1;
        end else if (st.last) begin
          cmd.tgt_set = 1'b1;
          cmd.tgt_top = 1'b1;
        end else begin
          cmd.step_i = 1'b1;
        end
      end
      lhbu_pkg::S_RAMP: cmd.res_sel = lhbu_pkg::RES_RAMP;
      lhbu_pkg::S_LOAD: begin
        cmd.load_wr = 1'b1;
        if (st.load_last) cmd.res_sel = lhbu_pkg::RES_LOAD;
      end
      lhbu_pkg::S_DONE: cmd.commit = st.out_free;
      default: cmd = '0;
    endcase
  end

  `LHBU_ASSERT_NEXT(a_accept_fetch, clk, rst_n, cmd.accept, state_r == lhbu_pkg::S_FETCH, "accepted request did not enter fetch")
  `LHBU_ASSERT_NEXT(a_hit_ramp, clk, rst_n, (state_r == lhbu_pkg::S_CMP) && st.hit, state_r == lhbu_pkg::S_RAMP, "threshold hit did not end the walk")
  `LHBU_ASSERT_IMPL(a_commit_done, clk, rst_n, cmd.commit, (state_r == lhbu_pkg::S_DONE) && st.out_free, "commit outside done state")

endmodule
`default_nettype wire

// ===== rtl/lhbu_dpath.sv =====
// Datapath: slot tables, threshold multiplier, blend ramp and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "lod_level_hysteresis_blender_unit_macros.svh"
module lhbu_dpath #(
  parameter int SLOTS  = lhbu_pkg::SLOTS_DEF,
  parameter int LEVELS = lhbu_pkg::LEVELS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lhbu_pkg::cfg_t                    cfg,
  input  wire  [lhbu_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                               in_tuser,
  input  lhbu_pkg::cmd_t                    cmd,
  output lhbu_pkg::status_t                 st,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [lhbu_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = SLOTS * LEVELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(LEVELS + 1);
  localparam logic [3:0] LEVELS_C = 4'(LEVELS);

  // Item registers
  logic                          func_r;
  logic [lhbu_pkg::SLOT_W-1:0]   slot_r;
  logic [lhbu_pkg::DIST_W-1:0]   cam_r;
  logic [lhbu_pkg::TIME_W-1:0]   ft_r;
  logic [lhbu_pkg::DIST_W-1:0]   d0_r, d1_r, d2_r, d3_r;

  logic [lhbu_pkg::SLOT_W-1:0]   in_slot;
  logic                          in_oor;
  logic [SW-1:0]                 in_idx;
  logic [AW-1:0]                 in_base;
  logic [SW-1:0]                 slot_idx;
  logic [AW-1:0]                 base;

  // Tables
  logic [lhbu_pkg::DIST_W-1:0]   dist_mem [DEPTH];
  lhbu_pkg::row_t                row_mem  [SLOTS];
  logic [SLOTS-1:0]              valid_r;
  logic [lhbu_pkg::DIST_W-1:0]   dist_rd_r;
  lhbu_pkg::row_t                row_rd_r;

  logic [IW-1:0]                 i_r;
  logic [lhbu_pkg::GAIN_W-1:0]   gain_hi_r, gain_lo_r, gain_sel;
  logic [lhbu_pkg::STEP_W-1:0]   step_r;
  logic [lhbu_pkg::PROD_W-1:0]   prod_r;
  logic [lhbu_pkg::LVL_W-1:0]    tgt_r;
  logic [lhbu_pkg::LVL_W-1:0]    top_eff;

  logic                          dist_we, dist_re, next_ok;
  logic [AW-1:0]                 dist_waddr, dist_raddr;
  logic [lhbu_pkg::DIST_W-1:0]   dist_wdata;

  // Result registers
  logic [lhbu_pkg::LVL_W-1:0]    res_cur_r, res_tgt_r;
  logic [lhbu_pkg::BLEND_W-1:0]  res_blend_r;
  logic                          res_vld_r, res_wr_r, res_load_r;

  logic [lhbu_pkg::LVL_W-1:0]    ramp_cur;
  logic [lhbu_pkg::BLEND_W-1:0]  ramp_blend;
  logic signed [lhbu_pkg::SUM_W-1:0] b_sum;

  logic                          out_tvalid_r;
  logic [lhbu_pkg::SLOT_W-1:0]   out_slot_r;
  logic [lhbu_pkg::LVL_W-1:0]    out_shown_r, out_want_r;
  logic [lhbu_pkg::BLEND_W-1:0]  out_blend_r;
  logic                          out_vld_r;
  logic                          out_free;

  assign in_slot  = in_tdata[lhbu_pkg::IN_SLOT_LSB +: lhbu_pkg::SLOT_W];
  assign in_oor   = int'(in_slot) >= SLOTS;
  assign in_idx   = SW'(in_slot);
  assign in_base  = AW'(int'(in_idx) * LEVELS);
  assign slot_idx = SW'(slot_r);
  assign base     = AW'(int'(slot_idx) * LEVELS);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_tuser;
      slot_r <= in_slot;
      cam_r  <= in_tdata[lhbu_pkg::IN_CAM_LSB +: lhbu_pkg::DIST_W];
      ft_r   <= in_tdata[lhbu_pkg::IN_FT_LSB +: lhbu_pkg::TIME_W];
      d0_r   <= in_tdata[lhbu_pkg::IN_D0_LSB +: lhbu_pkg::DIST_W];
      d1_r   <= in_tdata[lhbu_pkg::IN_D1_LSB +: lhbu_pkg::DIST_W];
      d2_r   <= in_tdata[lhbu_pkg::IN_D2_LSB +: lhbu_pkg::DIST_W];
      d3_r   <= in_tdata[lhbu_pkg::IN_D3_LSB +: lhbu_pkg::DIST_W];
    end
  end

  // Level counter: walk index for updates, write index for loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
    end else if (cmd.accept) begin
      i_r <= '0;
    end else if (cmd.step_i || cmd.load_wr) begin
      i_r <= i_r + IW'(1);
    end
  end

  // Distance table: one write and one registered read per cycle
  always_comb begin
    unique case (4'(i_r))
      4'd0:    dist_wdata = d0_r;
      4'd1:    dist_wdata = d1_r;
      4'd2:    dist_wdata = d2_r;
      4'd3:    dist_wdata = d3_r;
      default: dist_wdata = '0;
    endcase
  end

  assign next_ok    = (4'(i_r) + 4'd1) < LEVELS_C;
  assign dist_we    = cmd.load_wr;
  assign dist_waddr = AW'(int'(base) + int'(i_r));
  assign dist_re    = (cmd.accept && !in_oor) || (cmd.mul && next_ok);
  assign dist_raddr = cmd.accept ? in_base : AW'(int'(base) + int'(i_r) + 1);

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (dist_re) dist_rd_r <= dist_mem[dist_raddr];
  end

  // Slot state rows, read once per request and written at commit
  always_ff @(posedge clk) begin
    if (cmd.commit && res_wr_r) row_mem[slot_idx] <= '{cur: res_cur_r, tgt: res_tgt_r,
                                                       blend: res_blend_r};
    if (cmd.accept && !in_oor) row_rd_r <= row_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && res_load_r) begin
      valid_r[slot_idx] <= 1'b1;
    end
  end

  assign top_eff = (4'(cfg.top_level) > LEVELS_C) ? lhbu_pkg::LVL_W'(LEVELS) : cfg.top_level;

  // Gains and ramp step, then one threshold product per level
  assign gain_sel = (4'(row_rd_r.cur) <= 4'(i_r)) ? gain_hi_r : gain_lo_r;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      gain_hi_r <= lhbu_pkg::GAIN_W'(cfg.bias_gain)
                 * lhbu_pkg::GAIN_W'(lhbu_pkg::HYST_ONE + 9'(cfg.hyst_frac));
      gain_lo_r <= lhbu_pkg::GAIN_W'(cfg.bias_gain)
                 * lhbu_pkg::GAIN_W'(lhbu_pkg::HYST_ONE - 9'(cfg.hyst_frac));
      step_r    <= lhbu_pkg::STEP_W'((32'(cfg.ramp_speed) * 32'(ft_r)) >> 8);
    end
    if (cmd.mul) begin
      prod_r <= lhbu_pkg::PROD_W'(dist_rd_r) * lhbu_pkg::PROD_W'(gain_sel);
    end
    if (cmd.tgt_set) begin
      tgt_r <= cmd.tgt_top ? top_eff : lhbu_pkg::LVL_W'(i_r);
    end
  end

  // Blend ramp toward the wanted level
  always_comb begin
    b_sum      = '0;
    ramp_cur   = tgt_r;
    ramp_blend = '0;
    if (cfg.smooth_en && (row_rd_r.cur != tgt_r)) begin
      if (tgt_r > row_rd_r.cur) begin
        b_sum = $signed(lhbu_pkg::SUM_W'($signed(row_rd_r.blend)))
              + $signed({3'b000, step_r});
      end else begin
        b_sum = $signed(lhbu_pkg::SUM_W'($signed(row_rd_r.blend)))
              - $signed({3'b000, step_r});
      end
      if ((b_sum >= $signed(lhbu_pkg::BLEND_ONE)) || (b_sum <= 0)) begin
        ramp_cur   = tgt_r;
        ramp_blend = '0;
      end else begin
        ramp_cur   = row_rd_r.cur;
        ramp_blend = b_sum[lhbu_pkg::BLEND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      lhbu_pkg::RES_NONE: ;
      lhbu_pkg::RES_ZERO: begin
        res_cur_r <= '0; res_tgt_r <= '0; res_blend_r <= '0;
        res_vld_r <= 1'b0; res_wr_r <= 1'b0; res_load_r <= 1'b0;
      end
      lhbu_pkg::RES_LOAD: begin
        res_cur_r <= '0; res_tgt_r <= '0; res_blend_r <= '0;
        res_vld_r <= 1'b1; res_wr_r <= 1'b1; res_load_r <= 1'b1;
      end
      lhbu_pkg::RES_HOLD: begin
        res_cur_r <= row_rd_r.cur; res_tgt_r <= row_rd_r.tgt; res_blend_r <= row_rd_r.blend;
        res_vld_r <= 1'b1; res_wr_r <= 1'b0; res_load_r <= 1'b0;
      end
      lhbu_pkg::RES_RAMP: begin
        res_cur_r <= ramp_cur; res_tgt_r <= tgt_r; res_blend_r <= ramp_blend;
        res_vld_r <= 1'b1; res_wr_r <= 1'b1; res_load_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r  <= slot_r;
      out_shown_r <= res_cur_r;
      out_want_r  <= res_tgt_r;
      out_blend_r <= res_blend_r;
      out_vld_r   <= res_vld_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_vld_r;
  assign out_tdata  = lhbu_pkg::OUT_DATA_W'({out_blend_r, out_want_r, out_shown_r, out_slot_r});

  assign st.slot_oor  = int'(slot_r) >= SLOTS;
  assign st.is_load   = (func_r == lhbu_pkg::FUNC_LOAD);
  assign st.entry_ok  = !st.slot_oor && valid_r[slot_idx];
  assign st.enabled   = cfg.block_en;
  assign st.top_zero  = (top_eff == '0);
  assign st.hit       = lhbu_pkg::PROD_W'({cam_r, 16'h0000}) < prod_r;
  assign st.last      = (4'(i_r) + 4'd1) >= 4'(top_eff);
  assign st.load_last = (4'(i_r) == (LEVELS_C - 4'd1));
  assign st.out_free  = out_free;

  `LHBU_ASSERT_IMPL(a_blend_range, clk, rst_n, cmd.commit && res_wr_r, res_blend_r[lhbu_pkg::BLEND_W-1:16] == 2'b00, "stored blend outside zero to one")
  `LHBU_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.commit && res_load_r, valid_r[slot_idx], "loaded slot not marked valid")
  `LHBU_ASSERT_IMPL(a_res_levels, clk, rst_n, cmd.commit && res_wr_r, (4'(res_cur_r) <= LEVELS_C) && (4'(res_tgt_r) <= LEVELS_C), "level beyond table depth")

endmodule
`default_nettype wire

// ===== rtl/lod_level_hysteresis_blender_unit.sv =====
// Update: accept, fetch, multiply and compare for each of k levels (0..top), ramp, done,
// then out_tvalid. Load: fetch, one table write per level, done. Out-of-range, unloaded
// or disabled requests: fetch, done. One request at a time; next accept in the cycle
// after the commit. The walk is set by the distance table's single read port and the
// shared multiplier. Reset (rst_n low, synchronous): control, slot valid bits and config
// registers return to defaults; table contents are left as they are, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lod_level_hysteresis_blender_unit #(
  parameter int SLOTS  = lhbu_pkg::SLOTS_DEF,
  parameter int LEVELS = lhbu_pkg::LEVELS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Request channel
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // slot[3:0], camera_distance[27:4], frame_time[43:28], switch_dist_0[67:44],
  // switch_dist_1[91:68], switch_dist_2[115:92], switch_dist_3[139:116], zeros above
  input  wire  [lhbu_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[0]
  input  wire                               in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // out_slot[3:0], shown_level[6:4], wanted_level[9:7], blend_value[27:10], zeros above
  output logic [lhbu_pkg::OUT_DATA_W-1:0]   out_tdata,
  // slot_valid[0]
  output logic                              out_tuser,
  // Configuration write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [lhbu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [lhbu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [lhbu_pkg::BIAS_W-1:0]  bias_r;
  logic [lhbu_pkg::HYST_W-1:0]  hyst_r;
  logic [lhbu_pkg::SPEED_W-1:0] speed_r;
  logic [lhbu_pkg::LVL_W-1:0]   top_r;
  logic                         smooth_r;
  logic                         enable_r;
  logic [lhbu_pkg::BIAS_W-1:0]  bias_wr;
  logic                         cfg_we;

  lhbu_pkg::cfg_t    cfg;
  lhbu_pkg::cmd_t    cmd;
  lhbu_pkg::status_t st;

  // cfg_ready is tied high, so every write is taken; the port never stalls.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Clamp the bias to 0.5 .. 3.0 as it is written.
  always_comb begin
    bias_wr = cfg_data[lhbu_pkg::BIAS_W-1:0];
    if (bias_wr < lhbu_pkg::BIAS_MIN) bias_wr = lhbu_pkg::BIAS_MIN;
    if (bias_wr > lhbu_pkg::BIAS_MAX) bias_wr = lhbu_pkg::BIAS_MAX;
  end

  // Register file; indexes past the list drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= lhbu_pkg::BIAS_RST;
      hyst_r   <= lhbu_pkg::HYST_RST;
      speed_r  <= lhbu_pkg::SPEED_RST;
      top_r    <= lhbu_pkg::TOP_RST;
      smooth_r <= 1'b1;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lhbu_pkg::CFG_BIAS_GAIN:  bias_r   <= bias_wr;
        lhbu_pkg::CFG_HYST_FRAC:  hyst_r   <= cfg_data[lhbu_pkg::HYST_W-1:0];
        lhbu_pkg::CFG_RAMP_SPEED: speed_r  <= cfg_data[lhbu_pkg::SPEED_W-1:0];
        lhbu_pkg::CFG_TOP_LEVEL:  top_r    <= cfg_data[lhbu_pkg::LVL_W-1:0];
        lhbu_pkg::CFG_SMOOTH_EN:  smooth_r <= cfg_data[0];
        lhbu_pkg::CFG_BLOCK_EN:   enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.bias_gain  = bias_r;
  assign cfg.hyst_frac  = hyst_r;
  assign cfg.ramp_speed = speed_r;
  assign cfg.top_level  = top_r;
  assign cfg.smooth_en  = smooth_r;
  assign cfg.block_en   = enable_r;

  // Sequencer: accept, fetch the slot, walk levels or write the load, commit.
  lhbu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables, threshold multiplier, ramp and the output register that lets the
  // next request in while a result waits.
  lhbu_dpath #(
    .SLOTS  (SLOTS),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== sim/lod_result_checker.sv =====
// Result checker for the level-of-detail blender: watches all channels and predicts each result.
`timescale 1ns / 1ps
`default_nettype none
module lod_result_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  input  wire                                in_tready,
  input  wire  [lhbu_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                                in_tuser,
  input  wire                                out_tvalid,
  input  wire                                out_tready,
  input  wire  [lhbu_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                out_tuser,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire  [lhbu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lhbu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 mid_ramps
);
  import lhbu_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [LVL_W-1:0]   shown;
    logic [LVL_W-1:0]   wanted;
    logic [BLEND_W-1:0] blend;
    logic               valid;
  } lod_result_t;

  // Register copies
  logic [BIAS_W-1:0]  bias_q;
  logic [HYST_W-1:0]  hyst_q;
  logic [SPEED_W-1:0] speed_q;
  logic [LVL_W-1:0]   top_q;
  logic               smooth_q;
  logic               enable_q;

  // Object table copy
  logic [DIST_W-1:0] dist_tbl [SLOTS_DEF][LEVELS_DEF];
  bit                loaded   [SLOTS_DEF];
  int                shown_lvl[SLOTS_DEF];
  int                want_lvl [SLOTS_DEF];
  int                blend_acc[SLOTS_DEF];

  lod_result_t expected_q[$];
  int n_fail, n_checked, n_mid;

  // First level whose biased, hysteresis-adjusted distance lies beyond the camera.
  function automatic int choose_level(input int s, input logic [DIST_W-1:0] cam);
    longint unsigned lhs, thr, f;
    int lim, i;
    lim = (int'(top_q) > LEVELS_DEF) ? LEVELS_DEF : int'(top_q);
    lhs = longint'(cam) << 16;
    for (i = 0; i < lim; i++) begin
      f = (shown_lvl[s] <= i) ? longint'(HYST_ONE) + longint'(hyst_q)
                              : longint'(HYST_ONE) - longint'(hyst_q);
      thr = longint'(dist_tbl[s][i]) * longint'(bias_q) * f;
      if (lhs < thr) return i;
    end
    return lim;
  endfunction

  function automatic lod_result_t advance_object(input logic func,
                                                 input logic [SLOT_W-1:0] s,
                                                 input logic [DIST_W-1:0] cam,
                                                 input logic [TIME_W-1:0] ft,
                                                 input logic [4*DIST_W-1:0] d);
    lod_result_t r;
    int lvl, i;
    longint step, b;
    r = '0;
    r.slot = s;
    if (func == FUNC_LOAD) begin
      for (i = 0; i < LEVELS_DEF; i++) dist_tbl[s][i] = d[i*DIST_W +: DIST_W];
      shown_lvl[s] = 0;
      want_lvl[s]  = 0;
      blend_acc[s] = 0;
      loaded[s]    = 1'b1;
      r.valid      = 1'b1;
      return r;
    end
    if (!loaded[s]) return r;
    if (enable_q) begin
      lvl = choose_level(int'(s), cam);
      want_lvl[s] = lvl;
      if (smooth_q && shown_lvl[s] != lvl) begin
        step = (longint'(speed_q) * longint'(ft)) >>> 8;
        b = longint'(blend_acc[s]) + ((lvl > shown_lvl[s]) ? step : -step);
        // a finished or reversed ramp lands on the wanted level
        if (b >= longint'(BLEND_ONE) || b <= 0) begin
          shown_lvl[s] = lvl;
          b = 0;
        end
        blend_acc[s] = int'(b);
      end else begin
        shown_lvl[s] = lvl;
        blend_acc[s] = 0;
      end
    end
    r.shown  = LVL_W'(shown_lvl[s]);
    r.wanted = LVL_W'(want_lvl[s]);
    r.blend  = BLEND_W'(blend_acc[s]);
    r.valid  = 1'b1;
    return r;
  endfunction

  function automatic int field_diff(input string field, input int exp_v, input int act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    lod_result_t got, want, pred;
    logic [BIAS_W-1:0] b;
    if (!rst_n) begin
      bias_q   = BIAS_RST;
      hyst_q   = HYST_RST;
      speed_q  = SPEED_RST;
      top_q    = TOP_RST;
      smooth_q = 1'b1;
      enable_q = 1'b0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      expected_q.delete();
      n_fail    = 0;
      n_checked = 0;
      n_mid     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.slot   = out_tdata[OUT_SLOT_LSB +: SLOT_W];
        got.shown  = out_tdata[OUT_SHOWN_LSB +: LVL_W];
        got.wanted = out_tdata[OUT_WANT_LSB +: LVL_W];
        got.blend  = out_tdata[OUT_BLEND_LSB +: BLEND_W];
        got.valid  = out_tuser;
        if (expected_q.size() == 0) begin
          $display("%0t: result for slot %0d with none expected", $time, got.slot);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          n_fail += field_diff("out_slot", int'(want.slot), int'(got.slot));
          n_fail += field_diff("shown_level", int'(want.shown), int'(got.shown));
          n_fail += field_diff("wanted_level", int'(want.wanted), int'(got.wanted));
          n_fail += field_diff("blend_value", int'($signed(want.blend)),
                               int'($signed(got.blend)));
          n_fail += field_diff("slot_valid", int'(want.valid), int'(got.valid));
          n_checked++;
          if (want.blend != '0) n_mid++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIAS_GAIN: begin
            b = cfg_data[BIAS_W-1:0];
            bias_q = (b < BIAS_MIN) ? BIAS_MIN : (b > BIAS_MAX) ? BIAS_MAX : b;
          end
          CFG_HYST_FRAC:  hyst_q   = cfg_data[HYST_W-1:0];
          CFG_RAMP_SPEED: speed_q  = cfg_data[SPEED_W-1:0];
          CFG_TOP_LEVEL:  top_q    = cfg_data[LVL_W-1:0];
          CFG_SMOOTH_EN:  smooth_q = cfg_data[0];
          CFG_BLOCK_EN:   enable_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pred = advance_object(in_tuser,
                              in_tdata[IN_SLOT_LSB +: SLOT_W],
                              in_tdata[IN_CAM_LSB +: DIST_W],
                              in_tdata[IN_FT_LSB +: TIME_W],
                              in_tdata[IN_D0_LSB +: 4*DIST_W]);
        expected_q.insert(expected_q.size(), pred);
      end
    end
    fail_count <= n_fail;
    pending    <= expected_q.size();
    checked    <= n_checked;
    mid_ramps  <= n_mid;
  end

endmodule
`default_nettype wire

// ===== sim/lod_level_hysteresis_blender_unit_tb.sv =====
// Top testbench for the level-of-detail blender: drives requests and registers, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module lod_level_hysteresis_blender_unit_tb;
  import lhbu_pkg::*;

  // Indexes past the last register; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 128;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid;
  wire                   in_tready;
  // slot, camera_distance, frame_time, switch_dist_0..3, zeros above
  logic [IN_DATA_W-1:0]  in_tdata;
  // func
  logic                  in_tuser;
  wire                   out_tvalid;
  logic                  out_tready;
  // out_slot, shown_level, wanted_level, blend_value, zeros above
  wire  [OUT_DATA_W-1:0] out_tdata;
  // slot_valid
  wire                   out_tuser;
  logic                  cfg_valid;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails, pending, checked, mid_ramps;

  // Stimulus shaping only: where each slot's thresholds roughly sit
  logic [DIST_W-1:0] shadow_dist [SLOTS_DEF][LEVELS_DEF];
  bit                shadow_loaded[SLOTS_DEF];
  int                aim_lvl [SLOTS_DEF];
  int                bias_now = 384;
  int                hyst_now = 38;
  int                last_slot;

  bit in_gaps_on, out_gaps_on;
  int hold_req, hold_done;
  int n_loads, n_updates, n_cfg, quiet_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lod_level_hysteresis_blender_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lod_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .pending    (pending),
    .checked    (checked),
    .mid_ramps  (mid_ramps)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly ascending ladders of moderate size; some raw and some extreme tables
  function automatic logic [4*DIST_W-1:0] random_ladder();
    logic [4*DIST_W-1:0] d;
    logic [DIST_W-1:0]   v;
    int r, i;
    r = $urandom_range(0, 9);
    v = DIST_W'($urandom_range(0, 1 << 18));
    for (i = 0; i < 4; i++) begin
      if (r < 7) begin
        d[i*DIST_W +: DIST_W] = v;
        v = v + DIST_W'($urandom_range(1, 1 << 17));
      end else if (r < 9) begin
        d[i*DIST_W +: DIST_W] = DIST_W'($urandom);
      end else begin
        d[i*DIST_W +: DIST_W] = $urandom_range(0, 1) ? '1 : '0;
      end
    end
    return d;
  endfunction

  // Aim the camera near one level's switch distance so the hysteresis band gets hit
  function automatic logic [DIST_W-1:0] aim_camera(input int s);
    longint scaled;
    int r, i, off;
    if ($urandom_range(0, 4) == 0) aim_lvl[s] = $urandom_range(0, LEVELS_DEF);
    r = $urandom_range(0, 99);
    if (r < 8) return DIST_W'($urandom);
    if (r < 10) return '1;
    if (r < 12) return '0;
    i = (aim_lvl[s] < LEVELS_DEF) ? aim_lvl[s] : LEVELS_DEF - 1;
    off = int'($urandom_range(0, 2 * hyst_now + 4)) - hyst_now - 2;
    if (aim_lvl[s] >= LEVELS_DEF) off = off + hyst_now + 64;
    scaled = (longint'(shadow_dist[s][i]) * bias_now * (256 + off)) >>> 16;
    scaled = scaled + int'($urandom_range(0, 6)) - 3;
    if (scaled < 0) scaled = 0;
    if (scaled > longint'(24'hFFFFFF)) scaled = longint'(24'hFFFFFF);
    return DIST_W'(scaled);
  endfunction

  // Frame times mostly give partial steps, so ramps span several frames
  function automatic logic [TIME_W-1:0] random_frame_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return TIME_W'($urandom_range(200, 3000));
    if (r < 72) return '0;
    if (r < 85) return TIME_W'($urandom_range(3000, 20000));
    return TIME_W'($urandom);
  endfunction

  // Offer one request and hold it until accepted; valid stays high for the next one
  task automatic send_request(input logic func, input logic [SLOT_W-1:0] slot,
                              input logic [DIST_W-1:0] cam, input logic [TIME_W-1:0] ft,
                              input logic [4*DIST_W-1:0] d);
    int gap, i;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_DATA_W - IN_USED_W){1'b0}}, d, ft, cam, slot};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_LOAD) begin
      for (i = 0; i < LEVELS_DEF; i++) shadow_dist[slot][i] = d[i*DIST_W +: DIST_W];
      shadow_loaded[slot] = 1'b1;
      n_loads++;
    end else begin
      n_updates++;
    end
  endtask

  task automatic load_obj(input logic [SLOT_W-1:0] slot, input logic [4*DIST_W-1:0] d);
    send_request(FUNC_LOAD, slot, DIST_W'($urandom), TIME_W'($urandom), d);
  endtask

  task automatic update_obj(input logic [SLOT_W-1:0] slot, input logic [DIST_W-1:0] cam,
                            input logic [TIME_W-1:0] ft);
    send_request(FUNC_UPDATE, slot, cam, ft, {$urandom, $urandom, $urandom});
  endtask

  // Drop valid and hold until every expected result is back, then let the block settle
  task automatic idle_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, only once the block has gone idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    idle_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
    if (idx == CFG_BIAS_GAIN) begin
      bias_now = int'(data[BIAS_W-1:0]);
      if (bias_now < int'(BIAS_MIN)) bias_now = int'(BIAS_MIN);
      if (bias_now > int'(BIAS_MAX)) bias_now = int'(BIAS_MAX);
    end
    if (idx == CFG_HYST_FRAC) hyst_now = int'(data[HYST_W-1:0]);
  endtask

  // Each phase gets its own settings; the early ones pin the extremes
  task automatic config_phase(input int ph);
    logic [CFG_DATA_W-1:0] bias_raw, hyst_raw, speed_raw, top_raw;
    case (ph)
      0:       bias_raw = '0;
      1:       bias_raw = '1;
      2:       bias_raw = CFG_DATA_W'(BIAS_MIN);
      3:       bias_raw = CFG_DATA_W'(BIAS_MAX);
      default: bias_raw = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom)
                                                      : CFG_DATA_W'($urandom_range(100, 800));
    endcase
    hyst_raw = (ph == 0) ? '0 : (ph == 1) ? CFG_DATA_W'(255)
                                          : CFG_DATA_W'($urandom_range(0, 255));
    case (ph)
      2:       speed_raw = '0;
      3:       speed_raw = '1;
      default: speed_raw = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                                       : CFG_DATA_W'($urandom_range(128, 2048));
    endcase
    case (ph)
      4:       top_raw = CFG_DATA_W'(0);
      5:       top_raw = CFG_DATA_W'(7);
      6:       top_raw = CFG_DATA_W'(5);
      default: top_raw = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                     : CFG_DATA_W'($urandom_range(1, 4));
    endcase
    write_reg(CFG_BIAS_GAIN, bias_raw);
    write_reg(CFG_HYST_FRAC, hyst_raw);
    write_reg(CFG_RAMP_SPEED, speed_raw);
    write_reg(CFG_TOP_LEVEL, top_raw);
    write_reg(CFG_SMOOTH_EN, (ph == 7) ? '0 : CFG_DATA_W'($urandom_range(0, 7) != 0));
    write_reg(CFG_BLOCK_EN, (ph == 8) ? '0 : CFG_DATA_W'(1));
    write_reg((ph % 2) ? CFG_SPARE_7 : CFG_SPARE_6, CFG_DATA_W'($urandom));
  endtask

  // Favor the previous slot so ramps run over several consecutive frames
  task automatic random_request();
    int s;
    s = $urandom_range(0, 1) ? last_slot : $urandom_range(0, SLOTS_DEF - 1);
    last_slot = s;
    if ($urandom_range(0, 99) < 8 || !shadow_loaded[s])
      load_obj(SLOT_W'(s), random_ladder());
    else
      update_obj(SLOT_W'(s), aim_camera(s), random_frame_time());
    if ($urandom_range(0, 149) == 0) idle_until_drained();
  endtask

  // Result side: random back-pressure, plus long hold-offs on demand
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_done != hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        gap = out_gaps_on ? pick_gap() : 0;
        if (gap == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_tvalid   <= 1'b0;
    in_tuser    <= FUNC_LOAD;
    in_tdata    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_BIAS_GAIN;
    cfg_data    <= '0;
    in_gaps_on  <= 1'b1;
    out_gaps_on <= 1'b1;
    hold_req    <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unloaded slots return zeros, whether the block is disabled or not
    update_obj(4'd3, 24'd1000, 16'd1000);
    write_reg(CFG_BLOCK_EN, CFG_DATA_W'(1));
    update_obj(4'd15, 24'hFFFFFF, 16'hFFFF);

    // All-zero distances: nothing matches, so the top level wins; a long frame jumps at once
    load_obj(4'd0, '0);
    update_obj(4'd0, 24'd0, 16'hFFFF);
    update_obj(4'd0, 24'd0, 16'd0);

    // All-max distances: level 0 even at the far end
    load_obj(4'd15, '1);
    update_obj(4'd15, 24'hFFFFFF, 16'd1092);

    // Small ladder: ramp up over a few frames, finish, then drop at once
    load_obj(4'd1, {24'd204800, 24'd102400, 24'd51200, 24'd25600});
    repeat (3) update_obj(4'd1, 24'd120000, 16'd1092);
    update_obj(4'd1, 24'd120000, 16'hFFFF);
    update_obj(4'd1, 24'd1000, 16'd1092);
    update_obj(4'd1, 24'd120000, 16'hFFFF);
    // Inside the widened band below the shown level: stay put
    update_obj(4'd1, 24'd70000, 16'd1092);
    // Zero step on a level change switches at once
    update_obj(4'd1, 24'd200000, 16'd0);

    // Disabled block reports the stored state unchanged
    write_reg(CFG_BLOCK_EN, CFG_DATA_W'(0));
    update_obj(4'd1, 24'd0, 16'd1000);
    write_reg(CFG_BLOCK_EN, CFG_DATA_W'(1));

    for (int ph = 0; ph < PHASES; ph++) begin
      config_phase(ph);
      in_gaps_on  <= (ph % 3) == 0;
      out_gaps_on <= (ph % 3) != 1;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // Stall the result side while requests keep coming
        if ((ph == 1 || ph == 5) && j == 30) hold_req <= hold_req + 1;
        random_request();
      end
    end

    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d updates over %0d register writes (%0d settings).",
             n_loads, n_updates, n_cfg, PHASES + 2);
    $display("Checked %0d results, %0d caught mid-ramp; %0d mismatches.",
             checked, mid_ramps, fails);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== lod_level_hysteresis_blender_unit.f =====
+incdir+rtl
rtl/lhbu_pkg.sv
rtl/lhbu_ctrl.sv
rtl/lhbu_dpath.sv
rtl/lod_level_hysteresis_blender_unit.sv
sim/lod_result_checker.sv
sim/lod_level_hysteresis_blender_unit_tb.sv
